@@ src/olads_pkg.sv @@
`default_nettype none

package olads_pkg;

   // Request codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DELETED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   // One request item.
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] position;
      logic [5:0] list_length;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;      // capture a new request, rewind the scan
      logic       insert;    // append the key at the tail
      logic       advance;   // read the next held entry
      logic       move;      // write the previous read entry one place down
      logic       capture;   // remember the match position
      logic       dec;       // drop one entry from the count
      logic       result;    // load the output register
      logic [2:0] status;    // status code for the result
      logic       use_pos;   // report the match position
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       match;
      logic       exhausted;
      logic       rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ src/olads_ctrl.sv @@
`default_nettype none

module olads_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  olads_pkg::stat_type  stat,
   output olads_pkg::cmd_type   cmd
);
   import olads_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] status_ff, status_in;
   logic       use_pos_ff, use_pos_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      use_pos_in = use_pos_ff;
      cmd        = '0;
      cmd.status  = status_ff;
      cmd.use_pos = use_pos_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            use_pos_in = 1'b0;
            if (stat.op == OP_INSERT) begin
               if (stat.full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  status_in  = ST_INSERTED;
               end
               state_in = S_FINISH;
            end else if (stat.op == OP_DELETE && stat.empty) begin
               status_in = ST_EMPTY;
               state_in  = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.capture = 1'b1;
               use_pos_in  = 1'b1;
               if (stat.op == OP_DELETE) begin
                  state_in = S_SHIFT;
               end else begin
                  status_in = ST_FOUND;
                  state_in  = S_FINISH;
               end
            end else if (stat.exhausted) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.exhausted) begin
               cmd.dec   = 1'b1;
               status_in = ST_DELETED;
               state_in  = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               cmd.move    = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result code held until the output register takes it.
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      use_pos_ff <= use_pos_in;
   end

endmodule

`default_nettype wire

@@ src/olads_dp.sv @@
`default_nettype none

module olads_dp #(
   parameter int CAPACITY = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  olads_pkg::req_item_type  req_item,
   output logic                     rsp_valid,
   output olads_pkg::rsp_item_type  rsp_item,
   input  wire                      rsp_stall,
   input  olads_pkg::cmd_type       cmd,
   output olads_pkg::stat_type      stat
);
   import olads_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // List storage, one write port and one registered read port.
   logic [31:0] mem [CAPACITY];

   logic [1:0]       op_ff;
   logic [31:0]      key_ff;
   logic [CNT_W-1:0] used_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic             cmp_vld_ff;
   logic [31:0]      rd_data_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] wr_ptr_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic [CNT_W-1:0] ptr_dec;
   logic [31:0]      pos_wide;
   logic [31:0]      len_wide;
   logic             more;

   // Scan pointer still below the held count.
   assign more    = (ptr_ff < used_ff);
   assign ptr_dec = ptr_ff - 1'b1;

   // Memory port selection.
   assign rd_en   = cmd.advance && more;
   assign rd_addr = ptr_ff[IDX_W-1:0];
   assign wr_en   = cmd.insert || (cmd.move && cmp_vld_ff);
   assign wr_addr = cmd.insert ? used_ff[IDX_W-1:0] : wr_ptr_ff;
   assign wr_data = cmd.insert ? key_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Request capture, scan pointer and position tracking.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_item.req_type;
         key_ff <= req_item.key;
      end
      if (cmd.capture) begin
         pos_ff    <= ptr_dec[IDX_W-1:0];
         wr_ptr_ff <= ptr_dec[IDX_W-1:0];
      end else if (cmd.move && cmp_vld_ff) begin
         wr_ptr_ff <= wr_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_en;
         if (rd_en) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   // Held entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.insert) begin
         used_ff <= used_ff + 1'b1;
      end else if (cmd.dec) begin
         used_ff <= used_ff - 1'b1;
      end
   end

   // Output register.
   assign pos_wide = cmd.use_pos ? 32'(pos_ff) : 32'd0;
   assign len_wide = 32'(used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.position    <= pos_wide[4:0];
         rsp_ff.list_length <= len_wide[5:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Status toward the controller.
   assign stat.op        = op_ff;
   assign stat.full      = (used_ff == CAP_CNT);
   assign stat.empty     = (used_ff == '0);
   assign stat.match     = cmp_vld_ff && (rd_data_ff == key_ff);
   assign stat.exhausted = !cmp_vld_ff && !more;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

@@ src/ordered_list_append_delete_search_core.sv @@
`default_nettype none

// Bounded ordered list of signed 32-bit keys held in one on-chip memory of
// CAPACITY entries, head at index 0. Each request item appends a key at the
// tail, deletes the first equal entry (later entries move down one place),
// or searches for the first equal entry, and returns exactly one result item
// with a status, the match position and the new length. One request is in
// work at a time. An insert needs no scan; search and delete time grows with
// the held count, since the memory's single read port visits one entry per
// cycle, first while scanning up to the match and then while the entries
// behind it are moved down one place after a delete. A new request is taken
// the cycle after its predecessor's result is loaded, even while that result
// still waits on rsp_stall.
module ordered_list_append_delete_search_core #(
   parameter int CAPACITY = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  olads_pkg::req_item_type  req_item,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output olads_pkg::rsp_item_type  rsp_item,
   input  wire                      rsp_stall
);
   import olads_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   olads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, scan pointers and output register.
   olads_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

@@ src/olads_checker.sv @@
`default_nettype none

module olads_checker #(
   parameter int CAPACITY = 32
) (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input olads_pkg::req_item_type  req_item,
   input wire                      req_stall,
   input wire                      rsp_valid,
   input olads_pkg::rsp_item_type  rsp_item,
   input wire                      rsp_stall
);
   import olads_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // One item at a time: the cycle after an acceptance the input is stalled.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in work");

   // Only defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status <= ST_FULL)
      else $error("undefined status code");

   // Insert, full, empty and not-found results carry no position.
   a_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == ST_INSERTED || rsp_item.status == ST_FULL ||
                    rsp_item.status == ST_EMPTY || rsp_item.status == ST_NOT_FOUND)
      |-> rsp_item.position == 5'd0)
      else $error("position set on a result without a match");

   // The reported length never exceeds the capacity.
   a_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 63) || (32'(rsp_item.list_length) <= CAPACITY))
      else $error("length beyond capacity");

endmodule

bind ordered_list_append_delete_search_core olads_checker #(
   .CAPACITY (CAPACITY)
) u_olads_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_item  (req_item),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .rsp_stall (rsp_stall)
);

`default_nettype wire
